/* hw/rtl/pbrf_pkg.sv */
// shared types and constants for the polynomial bracketing root finder
package pbrf_pkg;

    localparam int MAX_DEGREE     = 6;
    localparam int NUM_COEF       = MAX_DEGREE + 1;
    localparam int MAX_ITERATIONS = 64;
    localparam int CIDX_W         = 3;
    localparam int SEC_DIV_STEPS  = 96;
    localparam int ERR_DIV_STEPS  = 64;

    localparam logic [CIDX_W-1:0] CFG_LIMIT = 3'd7;
    localparam logic [30:0] ERR_MAX   = 31'h7FFF_FFFF;
    localparam logic [63:0] T_CAP     = 64'h0000_0100_0000_0000;
    localparam logic [31:0] ERR_SCALE = 32'd6553600;
    localparam logic [63:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN   = 64'h8000_0000_0000_0000;

    localparam logic [1:0] ST_ITER  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_LIMIT = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_EV_INIT, OP_EV_MLO, OP_EV_MHI, OP_EV_ACC,
        OP_SAVE_FLO, OP_SAVE_FHI, OP_EMIT_BAD, OP_BIS, OP_SEC_MLO, OP_SEC_MHI,
        OP_SEC_SET, OP_DIV_STEP, OP_SEC_FIN, OP_UPD, OP_ERR_SET, OP_FINISH
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_EV_INIT, S_EV_MLO, S_EV_MHI, S_EV_ACC, S_SAVE, S_CHECK,
        S_EST, S_SEC_MHI, S_SEC_SET, S_SDIV, S_SEC_FIN, S_ERR_SET, S_EDIV,
        S_FINISH, S_NEXT
    } t_state;

    typedef enum logic [1:0] {
        PH_LO, PH_HI, PH_EST
    } t_phase;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic k_zero;
        logic div_last;
        logic bad;
        logic method;
        logic done;
    } t_stat;

endpackage

/* hw/rtl/pbrf_ctrl.sv */
// sequencer for evaluation, estimate, division and result steps
module pbrf_ctrl
    import pbrf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_LO;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EV_INIT;
                    n_phase = PH_LO;
                end
            end
            S_EV_INIT: n_state = S_EV_MLO;
            S_EV_MLO:  n_state = S_EV_MHI;
            S_EV_MHI:  n_state = S_EV_ACC;
            S_EV_ACC:  n_state = i_stat.k_zero ? S_SAVE : S_EV_MLO;
            S_SAVE: begin
                unique case (r_phase)
                    PH_LO: begin
                        n_state = S_EV_INIT;
                        n_phase = PH_HI;
                    end
                    PH_HI:   n_state = S_CHECK;
                    default: n_state = S_ERR_SET;
                endcase
            end
            S_CHECK: n_state = i_stat.bad ? S_IDLE : S_EST;
            S_EST: begin
                if (i_stat.method) begin
                    n_state = S_SEC_MHI;
                end else begin
                    n_state = S_EV_INIT;
                    n_phase = PH_EST;
                end
            end
            S_SEC_MHI: n_state = S_SEC_SET;
            S_SEC_SET: n_state = S_SDIV;
            S_SDIV:    n_state = i_stat.div_last ? S_SEC_FIN : S_SDIV;
            S_SEC_FIN: begin
                n_state = S_EV_INIT;
                n_phase = PH_EST;
            end
            S_ERR_SET: n_state = S_EDIV;
            S_EDIV:    n_state = i_stat.div_last ? S_FINISH : S_EDIV;
            S_FINISH:  n_state = S_NEXT;
            S_NEXT:    n_state = i_stat.done ? S_IDLE : S_EST;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE:    o_cmd.op = i_start ? OP_LOAD : OP_NONE;
            S_EV_INIT: o_cmd.op = OP_EV_INIT;
            S_EV_MLO:  o_cmd.op = OP_EV_MLO;
            S_EV_MHI:  o_cmd.op = OP_EV_MHI;
            S_EV_ACC:  o_cmd.op = OP_EV_ACC;
            S_SAVE: begin
                unique case (r_phase)
                    PH_LO:   o_cmd.op = OP_SAVE_FLO;
                    PH_HI:   o_cmd.op = OP_SAVE_FHI;
                    default: o_cmd.op = OP_UPD;
                endcase
            end
            S_CHECK:   o_cmd.op = i_stat.bad ? OP_EMIT_BAD : OP_NONE;
            S_EST:     o_cmd.op = i_stat.method ? OP_SEC_MLO : OP_BIS;
            S_SEC_MHI: o_cmd.op = OP_SEC_MHI;
            S_SEC_SET: o_cmd.op = OP_SEC_SET;
            S_SDIV:    o_cmd.op = OP_DIV_STEP;
            S_SEC_FIN: o_cmd.op = OP_SEC_FIN;
            S_ERR_SET: o_cmd.op = OP_ERR_SET;
            S_EDIV:    o_cmd.op = OP_DIV_STEP;
            S_FINISH:  o_cmd.op = OP_FINISH;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* hw/rtl/pbrf_dp.sv */
// datapath: coefficients, horner unit, shared multiplier, serial divider, result registers
module pbrf_dp
    import pbrf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_operation,
    input  logic [31:0]       i_lower_bound,
    input  logic [31:0]       i_upper_bound,
    input  logic [30:0]       i_tolerance_percent,
    output logic              o_valid,
    output logic [6:0]        o_iteration,
    output logic [31:0]       o_bracket_low,
    output logic [31:0]       o_bracket_high,
    output logic [31:0]       o_root_estimate,
    output logic [30:0]       o_relative_error_percent,
    output logic [1:0]        o_status,
    output logic              o_last
);

    logic [31:0]  r_coef [NUM_COEF];
    logic [6:0]   r_limit;
    logic         r_method;
    logic [30:0]  r_tol;
    logic [31:0]  r_lo, r_hi, r_x, r_est, r_prior;
    logic [63:0]  r_flo, r_fhi, r_acc, r_p0, r_p1;
    logic [2:0]   r_k;
    logic [127:0] r_num;
    logic [63:0]  r_rem, r_quo, r_dm;
    logic         r_over, r_nz, r_sneg;
    logic [6:0]   r_cnt, r_step;
    logic         r_valid, r_done;
    logic [6:0]   r_o_it;
    logic [31:0]  r_o_bl, r_o_bh, r_o_est;
    logic [30:0]  r_o_err;
    logic [1:0]   r_o_st;
    logic         r_o_last;

    logic [63:0]  acc_mag, fhi_mag, m_sum, m_val, hprod, coef_k, acc_next;
    logic [64:0]  hsum, den65, rem_sh;
    logic         hneg;
    logic [31:0]  x_mag, d_mag, dif_mag, est_mag;
    logic [32:0]  d33, s33, s_adj, dif33;
    logic [63:0]  den, dm_sec, qsel, tval, hi_t;
    logic         sec_neg;
    logic [95:0]  n96;
    logic [31:0]  mul_a, mul_b, sec_est;
    logic [63:0]  mul_p;
    logic         ge;
    logic [63:0]  rem_nx;
    logic [30:0]  err_q;
    logic [6:0]   step_n, lim_eff;
    logic [1:0]   st_n;
    logic         fl_z, fe_z;

    always_comb begin
        acc_mag = r_acc[63] ? (64'd0 - r_acc) : r_acc;
        x_mag   = r_x[31] ? (32'd0 - r_x) : r_x;
        fhi_mag = r_fhi[63] ? (64'd0 - r_fhi) : r_fhi;
        hneg    = r_acc[63] ^ r_x[31];

        // horner product: (|acc|*|x|) >> 16 from two partial products
        m_sum = (r_p1 << 16) + (r_p0 >> 16);
        m_val = (r_p1 >= 64'h0000_8000_0000_0000) ? '1 : m_sum;
        if (!hneg) hprod = m_val[63] ? S64_MAX : m_val;
        else       hprod = m_val[63] ? S64_MIN : (64'd0 - m_val);
        coef_k = {{32{r_coef[r_k][31]}}, r_coef[r_k]};
        hsum   = {hprod[63], hprod} + {coef_k[63], coef_k};
        if (hsum[64] != hsum[63]) acc_next = hsum[64] ? S64_MIN : S64_MAX;
        else                      acc_next = hsum[63:0];

        // false position terms
        d33   = {r_lo[31], r_lo} - {r_hi[31], r_hi};
        d_mag = d33[32] ? 32'(33'd0 - d33) : d33[31:0];
        den65 = {r_flo[63], r_flo} - {r_fhi[63], r_fhi};
        if (den65[64] != den65[63]) den = den65[64] ? S64_MIN : S64_MAX;
        else                        den = den65[63:0];
        dm_sec  = den[63] ? (64'd0 - den) : den;
        sec_neg = r_fhi[63] ^ d33[32] ^ den[63];
        n96     = {r_p1, 32'd0} + {32'd0, r_p0};

        if (r_dm == 64'd0)                      qsel = r_nz ? T_CAP : 64'd0;
        else if (r_over || (r_quo > T_CAP))     qsel = T_CAP;
        else                                    qsel = r_quo;
        tval = r_sneg ? (64'd0 - qsel) : qsel;
        hi_t = {{32{r_hi[31]}}, r_hi} - tval;
        if (!hi_t[63] && (hi_t[62:31] != 32'd0))      sec_est = 32'h7FFF_FFFF;
        else if (hi_t[63] && (hi_t[62:31] != '1))     sec_est = 32'h8000_0000;
        else                                          sec_est = hi_t[31:0];

        // bisection midpoint, truncated toward zero
        s33   = {r_lo[31], r_lo} + {r_hi[31], r_hi};
        s_adj = s33 + {32'd0, s33[32]};

        dif33   = {r_est[31], r_est} - {r_prior[31], r_prior};
        dif_mag = dif33[32] ? 32'(33'd0 - dif33) : dif33[31:0];
        est_mag = r_est[31] ? (32'd0 - r_est) : r_est;

        // shared 32x32 multiplier
        unique case (i_cmd.op)
            OP_EV_MLO:  begin mul_a = acc_mag[31:0];  mul_b = x_mag;     end
            OP_EV_MHI:  begin mul_a = acc_mag[63:32]; mul_b = x_mag;     end
            OP_SEC_MLO: begin mul_a = fhi_mag[31:0];  mul_b = d_mag;     end
            OP_SEC_MHI: begin mul_a = fhi_mag[63:32]; mul_b = d_mag;     end
            OP_UPD:     begin mul_a = dif_mag;        mul_b = ERR_SCALE; end
            default:    begin mul_a = 32'd0;          mul_b = 32'd0;     end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};

        // one restoring division step
        rem_sh = {r_rem, r_num[127]};
        ge     = rem_sh >= {1'b0, r_dm};
        rem_nx = ge ? 64'(rem_sh - {1'b0, r_dm}) : rem_sh[63:0];

        if (r_dm == 64'd0)                          err_q = r_nz ? ERR_MAX : 31'd0;
        else if (r_quo > {33'd0, ERR_MAX})          err_q = ERR_MAX;
        else                                        err_q = r_quo[30:0];
        if (r_limit == 7'd0)                        lim_eff = 7'd1;
        else if (r_limit > 7'(MAX_ITERATIONS))      lim_eff = 7'(MAX_ITERATIONS);
        else                                        lim_eff = r_limit;
        step_n = r_step + 7'd1;
        if (err_q < r_tol)             st_n = ST_CONV;
        else if (step_n >= lim_eff)    st_n = ST_LIMIT;
        else                           st_n = ST_ITER;

        fl_z = (r_flo == 64'd0);
        fe_z = (r_acc == 64'd0);
    end

    // configuration and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) r_coef[i] <= 32'd0;
            r_limit <= 7'(MAX_ITERATIONS);
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < CIDX_W'(NUM_COEF)) r_coef[i_cfg_idx] <= i_cfg_data;
                else if (i_cfg_idx == CFG_LIMIT)   r_limit <= i_cfg_data[6:0];
            end
            r_valid <= (i_cmd.op == OP_FINISH) || (i_cmd.op == OP_EMIT_BAD);
            if (i_cmd.op == OP_FINISH) r_done <= (st_n != ST_ITER);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_method <= i_operation;
                r_lo     <= i_lower_bound;
                r_hi     <= i_upper_bound;
                r_tol    <= i_tolerance_percent;
                r_x      <= i_lower_bound;
                r_prior  <= 32'd0;
                r_step   <= 7'd0;
            end
            OP_EV_INIT: begin
                r_acc <= {{32{r_coef[MAX_DEGREE][31]}}, r_coef[MAX_DEGREE]};
                r_k   <= 3'(MAX_DEGREE - 1);
            end
            OP_EV_MLO, OP_SEC_MLO: r_p0 <= mul_p;
            OP_EV_MHI, OP_SEC_MHI: r_p1 <= mul_p;
            OP_EV_ACC: begin
                r_acc <= acc_next;
                if (r_k != 3'd0) r_k <= r_k - 3'd1;
            end
            OP_SAVE_FLO: begin
                r_flo <= r_acc;
                r_x   <= r_hi;
            end
            OP_SAVE_FHI: r_fhi <= r_acc;
            OP_EMIT_BAD: begin
                r_o_it   <= 7'd0;
                r_o_bl   <= r_lo;
                r_o_bh   <= r_hi;
                r_o_est  <= 32'd0;
                r_o_err  <= 31'd0;
                r_o_st   <= ST_BAD;
                r_o_last <= 1'b1;
            end
            OP_BIS: begin
                r_est <= s_adj[32:1];
                r_x   <= s_adj[32:1];
            end
            OP_SEC_SET: begin
                r_num  <= {n96, 32'd0};
                r_dm   <= dm_sec;
                r_nz   <= (n96 != 96'd0);
                r_sneg <= sec_neg;
                r_rem  <= 64'd0;
                r_quo  <= 64'd0;
                r_over <= 1'b0;
                r_cnt  <= 7'(SEC_DIV_STEPS - 1);
            end
            OP_DIV_STEP: begin
                r_num <= {r_num[126:0], 1'b0};
                r_rem <= rem_nx;
                r_quo <= {r_quo[62:0], ge};
                if (r_quo[63]) r_over <= 1'b1;
                r_cnt <= r_cnt - 7'd1;
            end
            OP_SEC_FIN: begin
                r_est <= sec_est;
                r_x   <= sec_est;
            end
            OP_UPD: begin
                // sign compare of f(low) and f(est); zero keeps the bracket
                if (!fl_z && !fe_z) begin
                    if (r_flo[63] != r_acc[63]) begin
                        r_hi  <= r_est;
                        r_fhi <= r_acc;
                    end else begin
                        r_lo  <= r_est;
                        r_flo <= r_acc;
                    end
                end
                r_p0 <= mul_p;
            end
            OP_ERR_SET: begin
                r_num  <= {r_p0, 64'd0};
                r_dm   <= {32'd0, est_mag};
                r_nz   <= (r_p0 != 64'd0);
                r_rem  <= 64'd0;
                r_quo  <= 64'd0;
                r_over <= 1'b0;
                r_cnt  <= 7'(ERR_DIV_STEPS - 1);
            end
            OP_FINISH: begin
                r_o_it   <= step_n;
                r_o_bl   <= r_lo;
                r_o_bh   <= r_hi;
                r_o_est  <= r_est;
                r_o_err  <= err_q;
                r_o_st   <= st_n;
                r_o_last <= (st_n != ST_ITER);
                r_prior  <= r_est;
                r_step   <= step_n;
            end
            default: ;
        endcase
    end

    assign o_stat.k_zero   = (r_k == 3'd0);
    assign o_stat.div_last = (r_cnt == 7'd0);
    assign o_stat.bad      = fl_z || (r_fhi == 64'd0) || (r_flo[63] == r_fhi[63]);
    assign o_stat.method   = r_method;
    assign o_stat.done     = r_done;

    assign o_valid                  = r_valid;
    assign o_iteration              = r_o_it;
    assign o_bracket_low            = r_o_bl;
    assign o_bracket_high           = r_o_bh;
    assign o_root_estimate          = r_o_est;
    assign o_relative_error_percent = r_o_err;
    assign o_status                 = r_o_st;
    assign o_last                   = r_o_last;

endmodule

/* hw/rtl/polynomial_bracketing_root_finder.sv */
// top level: bracketing root finder, bisection or false position, Q16.16
// setup: horner passes at the lower and upper bounds and a bracket check; a bad bracket gives an invalid result
// each iteration: a horner pass plus a 64-step error division
// false position adds a 96-step secant division; up to 64 iterations per item
// shared 32x32 multiplier and one-bit-per-cycle serial divider; one item at a time
// results are shown one cycle each with o_valid; synchronous active-low reset returns to idle
module polynomial_bracketing_root_finder
    import pbrf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_operation,
    input  logic [31:0]       i_lower_bound,
    input  logic [31:0]       i_upper_bound,
    input  logic [30:0]       i_tolerance_percent,
    output logic              o_valid,
    output logic [6:0]        o_iteration,
    output logic [31:0]       o_bracket_low,
    output logic [31:0]       o_bracket_high,
    output logic [31:0]       o_root_estimate,
    output logic [30:0]       o_relative_error_percent,
    output logic [1:0]        o_status,
    output logic              o_last
);

    t_cmd  cmd;
    t_stat stat;

    pbrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pbrf_dp u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (cmd),
        .o_stat                   (stat),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_idx                (i_cfg_idx),
        .i_cfg_data               (i_cfg_data),
        .i_operation              (i_operation),
        .i_lower_bound            (i_lower_bound),
        .i_upper_bound            (i_upper_bound),
        .i_tolerance_percent      (i_tolerance_percent),
        .o_valid                  (o_valid),
        .o_iteration              (o_iteration),
        .o_bracket_low            (o_bracket_low),
        .o_bracket_high           (o_bracket_high),
        .o_root_estimate          (o_root_estimate),
        .o_relative_error_percent (o_relative_error_percent),
        .o_status                 (o_status),
        .o_last                   (o_last)
    );

endmodule
